// ----- design/rlsd_pkg.sv -----
// shared types and constants for the run-length slice decoder
package rlsd_pkg;

    localparam int unsigned    CFG_W        = 17;
    localparam logic [32:0]    MAX_DECODED  = 33'd65536;
    localparam int unsigned    OUT_LANES    = 4;
    localparam int unsigned    LANES_USED   = (OUT_LANES < 4) ? OUT_LANES : 4;

    localparam logic [1:0]     CFG_EXPECTED_SIZE = 2'd0;
    localparam logic [1:0]     CFG_WINDOW_OFFSET = 2'd1;
    localparam logic [1:0]     CFG_WINDOW_LENGTH = 2'd2;

    localparam logic [7:0]     LIT_MAX_CTRL = 8'd127;
    localparam logic [7:0]     REP_MIN_CTRL = 8'd129;
    localparam logic [8:0]     REP_BASE     = 9'd257;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_LIT,
        PH_REP
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEC,
        S_FLUSH,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic [7:0] enc_byte;
        logic       byte_present;
        logic       stream_end;
    } t_in;

    typedef struct packed {
        logic [7:0] lane0;
        logic [7:0] lane1;
        logic [7:0] lane2;
        logic [7:0] lane3;
        logic [2:0] lane_count;
        logic       final_status;
        logic       decode_ok;
        logic       run_last;
    } t_out;

endpackage

// ----- design/run_length_slice_decoder_core.sv -----
// top level of the run-length slice decoder: sequencer, window compare and output register
// One encoded byte is taken per item and the input is stalled until that item's results
// are queued. Each item passes through the decode state, where the window compare unit
// steps through one decoded byte per cycle while no full lane group waits on a stalled
// output, then through the flush state, which sends any partial group; each result also
// waits while the output side stalls. Decoded window bytes are packed up to four per
// result, and the item that ends the stream adds a status result.
module run_length_slice_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [rlsd_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rlsd_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rlsd_pkg::t_out                o_out
);

    localparam int unsigned W = rlsd_pkg::CFG_W;

    // configuration
    logic [W-1:0] r_exp_size;
    logic [W-1:0] r_win_off;
    logic [W-1:0] r_win_len;

    // stream state
    rlsd_pkg::t_phase r_phase,    n_phase;
    logic [7:0]       r_lit_left, n_lit_left;
    logic [7:0]       r_run,      n_run;
    logic [W-1:0]     r_pos,      n_pos;
    logic [W-1:0]     r_emit,     n_emit;
    logic             r_failed,   n_failed;
    logic             r_any,      n_any;

    // item sequencer
    rlsd_pkg::t_state r_state, n_state;
    logic [7:0]       r_left,  n_left;
    logic [7:0]       r_byte,  n_byte;
    logic             r_end,   n_end;
    logic [2:0]       r_fill,  n_fill;
    logic [7:0]       r_buf [4];
    logic [7:0]       n_buf [4];

    // output register
    logic             r_out_valid;
    rlsd_pkg::t_out   r_out;
    logic             push;
    rlsd_pkg::t_out   push_data;
    logic             can_push;

    logic             win_ok;
    logic             in_win;
    logic [W-1:0]     pos_rel;
    logic             lanes_full;

    assign o_in_stall  = (r_state != rlsd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign can_push    = !r_out_valid || !i_out_stall;
    assign lanes_full  = (r_fill == 3'(rlsd_pkg::LANES_USED));

    assign win_ok = ({16'd0, r_exp_size} <= rlsd_pkg::MAX_DECODED) &&
                    (r_win_off <= r_exp_size) &&
                    (r_win_len <= r_exp_size - r_win_off);

    // shared window compare, one decoded position per cycle unless a full group waits on a stalled output
    assign pos_rel = r_pos - r_win_off;
    assign in_win  = (r_pos >= r_win_off) && (pos_rel < r_win_len);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rlsd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rlsd_pkg::S_DEC;
                end
            end
            rlsd_pkg::S_DEC: begin
                if (r_left == 8'd0) begin
                    n_state = rlsd_pkg::S_FLUSH;
                end
            end
            rlsd_pkg::S_FLUSH: begin
                if (r_fill == 3'd0 || can_push) begin
                    n_state = r_end ? rlsd_pkg::S_STATUS : rlsd_pkg::S_IDLE;
                end
            end
            rlsd_pkg::S_STATUS: begin
                if (can_push) begin
                    n_state = rlsd_pkg::S_IDLE;
                end
            end
            default: n_state = rlsd_pkg::S_IDLE;
        endcase
    end

    // datapath and result outputs
    always_comb begin
        logic        fail_now;
        logic [W-1:0] ctrl_len;
        logic        fits;
        logic [8:0]  rep_len;

        n_phase    = r_phase;
        n_lit_left = r_lit_left;
        n_run      = r_run;
        n_pos      = r_pos;
        n_emit     = r_emit;
        n_failed   = r_failed;
        n_any      = r_any;
        n_left     = r_left;
        n_byte     = r_byte;
        n_end      = r_end;
        n_fill     = r_fill;
        n_buf      = r_buf;
        push       = 1'b0;
        push_data  = '0;
        fail_now   = r_failed | !win_ok;
        rep_len    = rlsd_pkg::REP_BASE - {1'b0, i_in.enc_byte};
        if (i_in.enc_byte <= rlsd_pkg::LIT_MAX_CTRL) begin
            ctrl_len = W'(i_in.enc_byte) + W'(1);
        end else begin
            ctrl_len = W'(rep_len);
        end
        fits = (r_pos <= r_exp_size) && (ctrl_len <= r_exp_size - r_pos);

        case (r_state)
            rlsd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_byte   = i_in.enc_byte;
                    n_end    = i_in.stream_end;
                    n_fill   = 3'd0;
                    n_left   = 8'd0;
                    n_failed = fail_now;
                    if (i_in.byte_present) begin
                        n_any = 1'b1;
                        if (!fail_now) begin
                            case (r_phase)
                                rlsd_pkg::PH_LIT: begin
                                    n_left     = 8'd1;
                                    n_lit_left = r_lit_left - 8'd1;
                                    if (r_lit_left == 8'd1) begin
                                        n_phase = rlsd_pkg::PH_CTRL;
                                    end
                                end
                                rlsd_pkg::PH_REP: begin
                                    n_left  = r_run;
                                    n_run   = 8'd0;
                                    n_phase = rlsd_pkg::PH_CTRL;
                                end
                                default: begin
                                    if (i_in.enc_byte <= rlsd_pkg::LIT_MAX_CTRL) begin
                                        if (fits) begin
                                            n_lit_left = 8'(ctrl_len);
                                            n_phase    = rlsd_pkg::PH_LIT;
                                        end else begin
                                            n_failed = 1'b1;
                                        end
                                    end else if (i_in.enc_byte >= rlsd_pkg::REP_MIN_CTRL) begin
                                        if (fits) begin
                                            n_run   = 8'(ctrl_len);
                                            n_phase = rlsd_pkg::PH_REP;
                                        end else begin
                                            n_failed = 1'b1;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            rlsd_pkg::S_DEC: begin
                if (r_left != 8'd0) begin
                    if (!in_win) begin
                        n_pos  = r_pos + W'(1);
                        n_left = r_left - 8'd1;
                    end else if (!lanes_full) begin
                        n_buf[r_fill[1:0]] = r_byte;
                        n_fill = r_fill + 3'd1;
                        n_emit = r_emit + W'(1);
                        n_pos  = r_pos + W'(1);
                        n_left = r_left - 8'd1;
                    end else if (can_push) begin
                        // full group goes out before this byte starts the next one
                        push                 = 1'b1;
                        push_data.lane0      = r_buf[0];
                        push_data.lane1      = (r_fill > 3'd1) ? r_buf[1] : 8'd0;
                        push_data.lane2      = (r_fill > 3'd2) ? r_buf[2] : 8'd0;
                        push_data.lane3      = (r_fill > 3'd3) ? r_buf[3] : 8'd0;
                        push_data.lane_count = r_fill;
                        n_buf[0] = r_byte;
                        n_fill   = 3'd1;
                        n_emit   = r_emit + W'(1);
                        n_pos    = r_pos + W'(1);
                        n_left   = r_left - 8'd1;
                    end
                end
            end
            rlsd_pkg::S_FLUSH: begin
                if (r_fill != 3'd0 && can_push) begin
                    push                 = 1'b1;
                    push_data.lane0      = r_buf[0];
                    push_data.lane1      = (r_fill > 3'd1) ? r_buf[1] : 8'd0;
                    push_data.lane2      = (r_fill > 3'd2) ? r_buf[2] : 8'd0;
                    push_data.lane3      = (r_fill > 3'd3) ? r_buf[3] : 8'd0;
                    push_data.lane_count = r_fill;
                    push_data.run_last   = !r_end;
                    n_fill               = 3'd0;
                end
            end
            rlsd_pkg::S_STATUS: begin
                if (can_push) begin
                    push                   = 1'b1;
                    push_data.final_status = 1'b1;
                    push_data.run_last     = 1'b1;
                    push_data.decode_ok    = !r_failed && win_ok &&
                                             (r_phase == rlsd_pkg::PH_CTRL) &&
                                             (r_pos == r_exp_size) &&
                                             (r_emit == r_win_len) &&
                                             (r_exp_size != '0 || !r_any);
                    n_phase    = rlsd_pkg::PH_CTRL;
                    n_lit_left = 8'd0;
                    n_run      = 8'd0;
                    n_pos      = '0;
                    n_emit     = '0;
                    n_failed   = 1'b0;
                    n_any      = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_size  <= '0;
            r_win_off   <= '0;
            r_win_len   <= '0;
            r_phase     <= rlsd_pkg::PH_CTRL;
            r_lit_left  <= 8'd0;
            r_run       <= 8'd0;
            r_pos       <= '0;
            r_emit      <= '0;
            r_failed    <= 1'b0;
            r_any       <= 1'b0;
            r_state     <= rlsd_pkg::S_IDLE;
            r_left      <= 8'd0;
            r_fill      <= 3'd0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rlsd_pkg::CFG_EXPECTED_SIZE: r_exp_size <= i_cfg_data;
                    rlsd_pkg::CFG_WINDOW_OFFSET: r_win_off  <= i_cfg_data;
                    rlsd_pkg::CFG_WINDOW_LENGTH: r_win_len  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_phase    <= n_phase;
            r_lit_left <= n_lit_left;
            r_run      <= n_run;
            r_pos      <= n_pos;
            r_emit     <= n_emit;
            r_failed   <= n_failed;
            r_any      <= n_any;
            r_state    <= n_state;
            r_left     <= n_left;
            r_fill     <= n_fill;
            r_end      <= n_end;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_buf  <= n_buf;
        if (push) begin
            r_out <= push_data;
        end
    end

endmodule
